>>> rtl/lsof_pkg.sv
`default_nettype none
package lsof_pkg;

    localparam int ROOT_STEPS = 18;
    localparam int QDEPTH     = 2;
    localparam logic [16:0] FAR_MM = 17'd100000;

    localparam logic [2:0] CFG_MIN_HEIGHT  = 3'd0;
    localparam logic [2:0] CFG_MAX_HEIGHT  = 3'd1;
    localparam logic [2:0] CFG_MAX_RADIUS  = 3'd2;
    localparam logic [2:0] CFG_AMBIENT     = 3'd3;
    localparam logic [2:0] CFG_VEG_ENABLE  = 3'd4;
    localparam logic [2:0] CFG_VEG_THRESH  = 3'd5;
    localparam logic [2:0] CFG_SECTORS     = 3'd6;

    typedef struct packed {
        logic signed [17:0] min_height;
        logic signed [17:0] max_height;
        logic [16:0]        max_radius;
        logic               ambient_present;
        logic               veg_filter_enable;
        logic [15:0]        veg_threshold;
        logic [5:0]         sectors_in_use;
    } cfg_t;

    typedef struct packed {
        logic               keep;
        logic               eos;
        logic signed [17:0] x;
        logic signed [17:0] y;
        logic signed [17:0] z;
        logic [16:0]        rad;
        logic [15:0]        nir;
        logic [4:0]         sec;
        logic [5:0]         n;
    } q_item_t;

    function automatic logic [31:0] atan_turn(input logic [4:0] i);
        logic [31:0] v;
        begin
            case (i)
                5'd0:  v = 32'd536870912;
                5'd1:  v = 32'd316933406;
                5'd2:  v = 32'd167458907;
                5'd3:  v = 32'd85004756;
                5'd4:  v = 32'd42667331;
                5'd5:  v = 32'd21354465;
                5'd6:  v = 32'd10679838;
                5'd7:  v = 32'd5340245;
                5'd8:  v = 32'd2670163;
                5'd9:  v = 32'd1335087;
                5'd10: v = 32'd667544;
                5'd11: v = 32'd333772;
                5'd12: v = 32'd166886;
                5'd13: v = 32'd83443;
                5'd14: v = 32'd41722;
                5'd15: v = 32'd20861;
                5'd16: v = 32'd10430;
                5'd17: v = 32'd5215;
                5'd18: v = 32'd2608;
                5'd19: v = 32'd1304;
                5'd20: v = 32'd652;
                5'd21: v = 32'd326;
                5'd22: v = 32'd163;
                5'd23: v = 32'd81;
                default: v = 32'd0;
            endcase
            return v;
        end
    endfunction

endpackage
`default_nettype wire

>>> rtl/lsof_queue.sv
`default_nettype none
module lsof_queue
    import lsof_pkg::*;
(
    input  wire logic    clk,
    input  wire logic    rst_n,
    input  wire logic    push,
    input  wire q_item_t push_item,
    output logic         full,
    input  wire logic    pop,
    output q_item_t      pop_item,
    output logic         empty
);

    localparam int PW = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;

    q_item_t mem [QDEPTH];
    logic [PW-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [PW:0]   count_reg;

    assign full     = (count_reg == (PW+1)'(QDEPTH));
    assign empty    = (count_reg == '0);
    assign pop_item = mem[rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (push && !full)
        begin
            mem[wr_ptr_reg] <= push_item;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push && !full)
            begin
                wr_ptr_reg <= (wr_ptr_reg == PW'(QDEPTH-1)) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (pop && !empty)
            begin
                rd_ptr_reg <= (rd_ptr_reg == PW'(QDEPTH-1)) ? '0 : rd_ptr_reg + 1'b1;
            end
            count_reg <= count_reg + (PW+1)'(push && !full) - (PW+1)'(pop && !empty);
        end
    end

endmodule
`default_nettype wire

>>> rtl/lsof_front.sv
`default_nettype none
module lsof_front
    import lsof_pkg::*;
#(
    parameter int MAX_SECTORS  = 16,
    parameter int CORDIC_STEPS = 16
)
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire cfg_t        cfg,
    input  wire logic        in_valid,
    output logic             in_ready,
    input  wire logic [17:0] in_x,
    input  wire logic [17:0] in_y,
    input  wire logic [17:0] in_z,
    input  wire logic        in_ret,
    input  wire logic [15:0] in_amb,
    input  wire logic        in_eos,
    output logic             push,
    output q_item_t          push_item,
    input  wire logic        q_full
);

    localparam logic [2:0] F_IDLE = 3'd0;
    localparam logic [2:0] F_SQ   = 3'd1;
    localparam logic [2:0] F_CHK  = 3'd2;
    localparam logic [2:0] F_ROOT = 3'd3;
    localparam logic [2:0] F_ROT  = 3'd4;
    localparam logic [2:0] F_SEC  = 3'd5;
    localparam logic [2:0] F_PUSH = 3'd6;

    logic [2:0] state_reg, state_next;
    logic [4:0] cnt_reg;

    logic signed [17:0] x_reg, y_reg, z_reg;
    logic               ret_reg, eos_reg, keep_reg;
    logic [15:0]        nir_reg;
    logic [35:0]        xsq_reg, ysq_reg;
    logic [33:0]        rmax_reg;
    logic [35:0]        v_reg, r_reg, bit_reg;
    logic signed [33:0] cx_reg, cy_reg, a_reg;
    logic [1:0]         quad_reg;
    logic [4:0]         sec_reg;
    logic [5:0]         n_reg;

    logic signed [35:0] xsq_full, ysq_full;
    logic [35:0]        hsq;
    logic               drop;
    logic [5:0]         n_eff;
    logic signed [33:0] xe, ye, dx, dy;
    logic [35:0]        rb;
    logic [29:0]        a_clamp;
    logic [37:0]        prod;
    logic [5:0]         sec_raw;

    assign xsq_full = x_reg * x_reg;
    assign ysq_full = y_reg * y_reg;
    assign hsq      = xsq_reg + ysq_reg;
    assign xe       = 34'(x_reg);
    assign ye       = 34'(y_reg);
    assign dx       = cy_reg >>> cnt_reg;
    assign dy       = cx_reg >>> cnt_reg;
    assign rb       = r_reg + bit_reg;

    always_comb
    begin
        if (cfg.sectors_in_use == 6'd0)
            n_eff = 6'd1;
        else if (cfg.sectors_in_use > 6'(MAX_SECTORS))
            n_eff = 6'(MAX_SECTORS);
        else
            n_eff = cfg.sectors_in_use;
    end

    assign drop = !ret_reg || (x_reg == 0 && y_reg == 0 && z_reg == 0)
               || (z_reg < cfg.min_height) || (z_reg > cfg.max_height)
               || (hsq > {2'b00, rmax_reg})
               || (cfg.veg_filter_enable && cfg.ambient_present
                   && (nir_reg > cfg.veg_threshold));

    always_comb
    begin
        if (a_reg < 0)
            a_clamp = '0;
        else if (a_reg > 34'sd1073741823)
            a_clamp = '1;
        else
            a_clamp = a_reg[29:0];
    end

    assign prod    = {quad_reg, a_clamp} * n_reg;
    assign sec_raw = prod[37:32];

    assign in_ready = (state_reg == F_IDLE);
    assign push     = (state_reg == F_PUSH);

    always_comb
    begin
        push_item      = '0;
        push_item.keep = keep_reg;
        push_item.eos  = eos_reg;
        push_item.x    = x_reg;
        push_item.y    = y_reg;
        push_item.z    = z_reg;
        push_item.rad  = r_reg[16:0];
        push_item.nir  = nir_reg;
        push_item.sec  = sec_reg;
        push_item.n    = n_reg;
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            F_IDLE: if (in_valid) state_next = F_SQ;
            F_SQ:   state_next = F_CHK;
            F_CHK:
            begin
                if (drop)
                    state_next = eos_reg ? F_PUSH : F_IDLE;
                else
                    state_next = F_ROOT;
            end
            F_ROOT: if (cnt_reg == 5'(ROOT_STEPS-1)) state_next = F_ROT;
            F_ROT:  if (cnt_reg == 5'(CORDIC_STEPS-1)) state_next = F_SEC;
            F_SEC:  state_next = F_PUSH;
            F_PUSH: if (!q_full) state_next = F_IDLE;
            default: state_next = F_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= F_IDLE;
            cnt_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            if (state_next != state_reg)
                cnt_reg <= '0;
            else
                cnt_reg <= cnt_reg + 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        case (state_reg)
            F_IDLE:
            begin
                x_reg    <= in_x;
                y_reg    <= in_y;
                z_reg    <= in_z;
                ret_reg  <= in_ret;
                eos_reg  <= in_eos;
                nir_reg  <= cfg.ambient_present ? in_amb : 16'd0;
                keep_reg <= 1'b0;
            end
            F_SQ:
            begin
                xsq_reg  <= 36'(xsq_full);
                ysq_reg  <= 36'(ysq_full);
                rmax_reg <= cfg.max_radius * cfg.max_radius;
                n_reg    <= n_eff;
            end
            F_CHK:
            begin
                keep_reg <= !drop;
                v_reg    <= hsq;
                r_reg    <= '0;
                bit_reg  <= 36'h4_0000_0000;
                a_reg    <= '0;
                if (x_reg == 0 && y_reg == 0)
                begin
                    quad_reg <= 2'd0;
                    cx_reg   <= '0;
                    cy_reg   <= '0;
                end
                else if (x_reg > 0 && y_reg >= 0)
                begin
                    quad_reg <= 2'd0;
                    cx_reg   <= xe <<< 12;
                    cy_reg   <= ye <<< 12;
                end
                else if (x_reg <= 0 && y_reg > 0)
                begin
                    quad_reg <= 2'd1;
                    cx_reg   <= ye <<< 12;
                    cy_reg   <= (-xe) <<< 12;
                end
                else if (x_reg < 0 && y_reg <= 0)
                begin
                    quad_reg <= 2'd2;
                    cx_reg   <= (-xe) <<< 12;
                    cy_reg   <= (-ye) <<< 12;
                end
                else
                begin
                    quad_reg <= 2'd3;
                    cx_reg   <= (-ye) <<< 12;
                    cy_reg   <= xe <<< 12;
                end
            end
            F_ROOT:
            begin
                if (v_reg >= rb)
                begin
                    v_reg <= v_reg - rb;
                    r_reg <= (r_reg >> 1) + bit_reg;
                end
                else
                begin
                    r_reg <= r_reg >> 1;
                end
                bit_reg <= bit_reg >> 2;
            end
            F_ROT:
            begin
                if (cy_reg > 0)
                begin
                    cx_reg <= cx_reg + dx;
                    cy_reg <= cy_reg - dy;
                    a_reg  <= a_reg + $signed({2'b00, atan_turn(cnt_reg)});
                end
                else if (cy_reg < 0)
                begin
                    cx_reg <= cx_reg - dx;
                    cy_reg <= cy_reg + dy;
                    a_reg  <= a_reg - $signed({2'b00, atan_turn(cnt_reg)});
                end
            end
            F_SEC:
            begin
                sec_reg <= (sec_raw > n_reg - 1'b1) ? 5'(n_reg - 1'b1) : sec_raw[4:0];
            end
            default:
            begin
            end
        endcase
    end

endmodule
`default_nettype wire

>>> rtl/lsof_back.sv
`default_nettype none
module lsof_back
    import lsof_pkg::*;
#(
    parameter int MAX_SECTORS = 16
)
(
    input  wire logic    clk,
    input  wire logic    rst_n,
    input  wire q_item_t pop_item,
    input  wire logic    q_empty,
    output logic         pop,
    output logic         out_valid,
    input  wire logic    out_ready,
    output logic         out_kind,
    output logic [109:0] out_data,
    output logic         out_last
);

    localparam int SEC_W = (MAX_SECTORS > 1) ? $clog2(MAX_SECTORS) : 1;

    localparam logic [1:0] B_IDLE  = 2'd0;
    localparam logic [1:0] B_POINT = 2'd1;
    localparam logic [1:0] B_SUM   = 2'd2;
    localparam logic [1:0] B_CLR   = 2'd3;

    logic [1:0] state_reg;
    q_item_t    item_reg;
    logic [5:0] s_reg;
    logic [16:0] nearest_reg [MAX_SECTORS];
    logic [MAX_SECTORS-1:0] hit_reg;
    logic       valid_reg;
    logic       kind_reg, last_reg;
    logic [109:0] data_reg;

    logic         out_free;
    logic [SEC_W-1:0] idx;
    logic [16:0]  near_rd;

    assign out_free  = !valid_reg || out_ready;
    assign pop       = (state_reg == B_IDLE) && !q_empty;
    assign idx       = (state_reg == B_SUM) ? s_reg[SEC_W-1:0] : item_reg.sec[SEC_W-1:0];
    assign near_rd   = nearest_reg[idx];
    assign out_valid = valid_reg;
    assign out_kind  = kind_reg;
    assign out_data  = data_reg;
    assign out_last  = last_reg;

    always_ff @(posedge clk)
    begin
        if (state_reg == B_IDLE && !q_empty)
            item_reg <= pop_item;
        if (out_free && state_reg == B_POINT)
        begin
            kind_reg <= 1'b0;
            last_reg <= !item_reg.eos;
            data_reg <= {1'b0, 17'd0, item_reg.sec, item_reg.nir, item_reg.rad,
                         item_reg.z, item_reg.y, item_reg.x};
        end
        else if (out_free && state_reg == B_SUM)
        begin
            kind_reg <= 1'b1;
            last_reg <= (s_reg == item_reg.n - 1'b1);
            data_reg <= {hit_reg[idx], near_rd, s_reg[4:0], 87'd0};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= B_IDLE;
            s_reg     <= '0;
            valid_reg <= 1'b0;
            hit_reg   <= '0;
            for (int i = 0; i < MAX_SECTORS; i++)
                nearest_reg[i] <= FAR_MM;
        end
        else
        begin
            if (out_free && (state_reg == B_POINT || state_reg == B_SUM))
                valid_reg <= 1'b1;
            else if (out_ready)
                valid_reg <= 1'b0;

            case (state_reg)
                B_IDLE:
                begin
                    s_reg <= '0;
                    if (!q_empty)
                        state_reg <= pop_item.keep ? B_POINT : B_SUM;
                end
                B_POINT:
                begin
                    if (out_free)
                    begin
                        if (item_reg.rad < near_rd)
                        begin
                            nearest_reg[idx] <= item_reg.rad;
                            hit_reg[idx]     <= 1'b1;
                        end
                        state_reg <= item_reg.eos ? B_SUM : B_IDLE;
                    end
                end
                B_SUM:
                begin
                    if (out_free)
                    begin
                        if (s_reg == item_reg.n - 1'b1)
                            state_reg <= B_CLR;
                        else
                            s_reg <= s_reg + 1'b1;
                    end
                end
                B_CLR:
                begin
                    hit_reg <= '0;
                    for (int i = 0; i < MAX_SECTORS; i++)
                        nearest_reg[i] <= FAR_MM;
                    state_reg <= B_IDLE;
                end
                default: state_reg <= B_IDLE;
            endcase
        end
    end

endmodule
`default_nettype wire

>>> rtl/lidar_sector_obstacle_filter.sv
// channel  | handshake                      | payload (low bit first)
// ---------+--------------------------------+------------------------------------------
// points   | s_axis_tvalid / s_axis_tready  | tdata: coord_x, coord_y, coord_z, ambient
//          |                                | tuser: has_return, tlast: end_of_scan
// results  | m_axis_tvalid / m_axis_tready  | tdata: out_x .. sector_hit, tuser: kind
// config   | cfg_we                         | cfg_index, cfg_data
//
// A kept point runs in the front end through squares, checks, an 18-step square root and
// the CORDIC loop, one step a cycle in turn; a dropped point leaves after the checks,
// through the push state only when it ends a scan.
// A two-word queue parts the front end from the sector table and output register; a point
// word passes idle and point states; summaries one word a cycle unless stalled, then a clear.
// Reset clears the sector table at once and loads the register defaults.
// Either side may stall; the output register holds its word until taken.
`default_nettype none
module lidar_sector_obstacle_filter
    import lsof_pkg::*;
#(
    parameter int MAX_SECTORS  = 16,
    parameter int CORDIC_STEPS = 16
)
(
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  wire logic         s_axis_tvalid,
    output logic              s_axis_tready,
    input  wire logic [71:0]  s_axis_tdata,  // coord_x, coord_y, coord_z, ambient, pad
    input  wire logic         s_axis_tuser,  // has_return
    input  wire logic         s_axis_tlast,
    output logic              m_axis_tvalid,
    input  wire logic         m_axis_tready,
    // out_x, out_y, out_z, radius, nearir, sector_number, sector_nearest, sector_hit, pad
    output logic [111:0]      m_axis_tdata,
    output logic              m_axis_tuser,  // kind
    output logic              m_axis_tlast,
    input  wire logic         cfg_we,
    input  wire logic [2:0]   cfg_index,
    input  wire logic [17:0]  cfg_data
);

    cfg_t    cfg_reg;
    q_item_t push_item, pop_item;
    logic    push, pop, q_full, q_empty;
    logic [109:0] out_data;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.min_height        <= -18'sd500;
            cfg_reg.max_height        <= 18'sd2000;
            cfg_reg.max_radius        <= 17'd10000;
            cfg_reg.ambient_present   <= 1'b0;
            cfg_reg.veg_filter_enable <= 1'b0;
            cfg_reg.veg_threshold     <= 16'hFFFF;
            cfg_reg.sectors_in_use    <= 6'd16;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_MIN_HEIGHT: cfg_reg.min_height        <= cfg_data;
                CFG_MAX_HEIGHT: cfg_reg.max_height        <= cfg_data;
                CFG_MAX_RADIUS: cfg_reg.max_radius        <= cfg_data[16:0];
                CFG_AMBIENT:    cfg_reg.ambient_present   <= cfg_data[0];
                CFG_VEG_ENABLE: cfg_reg.veg_filter_enable <= cfg_data[0];
                CFG_VEG_THRESH: cfg_reg.veg_threshold     <= cfg_data[15:0];
                CFG_SECTORS:    cfg_reg.sectors_in_use    <= cfg_data[5:0];
                default:
                begin
                end
            endcase
        end
    end

    lsof_front #(
        .MAX_SECTORS  (MAX_SECTORS),
        .CORDIC_STEPS (CORDIC_STEPS)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg_reg),
        .in_valid  (s_axis_tvalid),
        .in_ready  (s_axis_tready),
        .in_x      (s_axis_tdata[17:0]),
        .in_y      (s_axis_tdata[35:18]),
        .in_z      (s_axis_tdata[53:36]),
        .in_ret    (s_axis_tuser),
        .in_amb    (s_axis_tdata[69:54]),
        .in_eos    (s_axis_tlast),
        .push      (push),
        .push_item (push_item),
        .q_full    (q_full)
    );

    lsof_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_item (push_item),
        .full      (q_full),
        .pop       (pop),
        .pop_item  (pop_item),
        .empty     (q_empty)
    );

    lsof_back #(
        .MAX_SECTORS (MAX_SECTORS)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .pop_item  (pop_item),
        .q_empty   (q_empty),
        .pop       (pop),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .out_kind  (m_axis_tuser),
        .out_data  (out_data),
        .out_last  (m_axis_tlast)
    );

    assign m_axis_tdata = {2'b00, out_data};

endmodule
`default_nettype wire
